// ----- sv/epsc_pkg.sv -----
// Shared constants and types for the encoder PI speed controller.
// No dependencies; imported by encoder_pi_speed_controller_unit.
package epsc_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int SPEED_W  = 24;
    localparam int ERR_W    = 25;
    localparam int DUTY_W   = 8;
    localparam int TICK_W   = 16;

    // speed = |diff| * 15000 * 1024 / (cpr * dt)
    localparam int SPD_SCALE = 15000;
    localparam int SPD_SHIFT = 10;
    localparam int MILLI     = 1000;
    localparam int FF_SCALE  = 256000;
    // floor(x / 1000) = (x * DIV1000_RECIP) >> DIV1000_SHIFT for x < 2**18
    localparam int DIV1000_RECIP = 268436;
    localparam int DIV1000_SHIFT = 28;
    // duty saturates at 256 * 65536000
    localparam longint DUTY_FULL = 64'd16777216000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_SPEED   = 3'd0,
        CFG_PROP_GAIN      = 3'd1,
        CFG_INTEG_GAIN     = 3'd2,
        CFG_FRICTION_FF    = 3'd3,
        CFG_INTEGRAL_LIMIT = 3'd4,
        CFG_ENC_CPR        = 3'd5,
        CFG_SAMPLE_PERIOD  = 3'd6
    } t_cfg_reg;

endpackage

// ----- sv/encoder_pi_speed_controller_unit.sv -----
// Encoder speed measurement and PI motor speed controller, top level.
// Depends on epsc_pkg for constants and the register index type.
//
// Encoder edges (tuser = 0) update the position count; millisecond ticks
// (tuser = 1) advance the window counter. A tick that closes the sample window
// starts a control update run by a small sequencer around one shared 33x27
// signed multiplier and a radix-2 restoring divider: the request side is not
// ready while the update runs (14 sequencer steps and 24 divide steps; the
// divide steps are skipped when the measured speed saturates, and one
// sequencer step when the duty clamps). The result waits in its own output
// register, so counting resumes while it is pending. Configuration is always
// ready; zero sample period and zero counts per revolution act as 1.
module encoder_pi_speed_controller_unit
    import epsc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [0] chan_b_level
    input  logic                 s_axis_tuser,   // [0] kind
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // [7:0] pwm_duty, [31:8] measured_speed,
                                                 // [56:32] speed_error
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int MAG_W   = 41;
    localparam int MW      = (COUNT_WIDTH > MAG_W) ? COUNT_WIDTH : MAG_W;
    localparam int DVD_W   = 64;
    localparam int DEN_W   = 32;
    localparam int DIV_STEPS = SPEED_W;
    localparam int CNT_W   = $clog2(DIV_STEPS);
    localparam int LIM_W   = 26;
    localparam int INT_W   = 27;
    localparam int SUM_W   = 42;
    localparam int NUM_W   = 53;
    localparam int MA_W    = 33;
    localparam int MB_W    = 27;
    localparam int MP_W    = MA_W + MB_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_DEN,
        S_DIV_CHK,
        S_DIV,
        S_ERR,
        S_MUL_EDT,
        S_INTEG,
        S_MUL_PE,
        S_MUL_IA,
        S_MUL_FF,
        S_SUM,
        S_DUTY,
        S_DUTY2,
        S_DONE
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0] r_target;
    logic [CFG_W-1:0] r_kp;
    logic [CFG_W-1:0] r_ki;
    logic [CFG_W-1:0] r_ff;
    logic [CFG_W-1:0] r_ilim;
    logic [CFG_W-1:0] r_cpr;
    logic [CFG_W-1:0] r_period;

    logic [COUNT_WIDTH-1:0] r_pos;
    logic [COUNT_WIDTH-1:0] r_last;
    logic [TICK_W-1:0]      r_ticks;
    logic signed [INT_W-1:0] r_integ;

    logic [TICK_W-1:0]       r_dt;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_big;
    logic [37:0]             r_plo;
    logic [DVD_W-1:0]        r_dvd;
    logic [DEN_W-1:0]        r_rem;
    logic [DEN_W-1:0]        r_den;
    logic [CNT_W-1:0]        r_cnt;
    logic [SPEED_W-1:0]      r_speed;
    logic signed [ERR_W-1:0] r_err;
    logic [LIM_W-1:0]        r_lim;
    logic signed [NUM_W-1:0] r_num;
    logic [DUTY_W-1:0]       r_duty;
    logic signed [MP_W-1:0]  r_prod;

    logic                    r_out_valid;
    logic [DUTY_W-1:0]       r_o_duty;
    logic [SPEED_W-1:0]      r_o_speed;
    logic [ERR_W-1:0]        r_o_err;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;

    logic                   in_acc;
    logic                   out_acc;
    logic [TICK_W-1:0]      ticks_inc;
    logic [TICK_W-1:0]      period_eff;
    logic [CFG_W-1:0]       cpr_eff;
    logic [COUNT_WIDTH-1:0] pos_diff;
    logic [COUNT_WIDTH-1:0] pos_mag;
    logic [MW-1:0]          mag_ext;
    logic [53:0]            spd_prod;
    logic [DEN_W:0]         rem_sh;
    logic signed [SUM_W-1:0] integ_sum;
    logic signed [SUM_W-1:0] lim_pos;
    logic signed [SUM_W-1:0] lim_neg;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = r_out_valid && m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_o_err, r_o_speed, r_o_duty};

    assign ticks_inc  = r_ticks + TICK_W'(1);
    assign period_eff = (r_period == '0) ? TICK_W'(1) : r_period;
    assign cpr_eff    = (r_cpr == '0) ? CFG_W'(1) : r_cpr;
    assign pos_diff   = r_pos - r_last;
    assign pos_mag    = pos_diff[COUNT_WIDTH-1] ? (COUNT_WIDTH'(0) - pos_diff) : pos_diff;
    assign mag_ext    = MW'(pos_mag);

    assign spd_prod = {r_prod[29:0], 24'd0} + {16'd0, r_plo};
    assign rem_sh   = {r_rem, r_dvd[SPEED_W-1]};

    assign integ_sum = SUM_W'(r_integ) + SUM_W'($signed(r_prod[40:0]));
    assign lim_pos   = $signed({{(SUM_W-LIM_W){1'b0}}, r_lim});
    assign lim_neg   = -lim_pos;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL_LO: begin
                mul_a = MA_W'(r_mag[23:0]);
                mul_b = MB_W'(SPD_SCALE);
            end
            S_MUL_HI: begin
                mul_a = MA_W'(r_mag[MAG_W-1:24]);
                mul_b = MB_W'(SPD_SCALE);
            end
            S_MUL_DEN: begin
                mul_a = MA_W'(cpr_eff);
                mul_b = MB_W'(r_dt);
            end
            S_ERR: begin
                mul_a = MA_W'(r_ilim);
                mul_b = MB_W'(MILLI);
            end
            S_MUL_EDT: begin
                mul_a = MA_W'(r_err);
                mul_b = MB_W'(r_dt);
            end
            S_INTEG: begin
                mul_a = MA_W'(r_kp);
                mul_b = MB_W'(MILLI);
            end
            S_MUL_PE: begin
                mul_a = MA_W'(r_prod[LIM_W-1:0]);
                mul_b = MB_W'(r_err);
            end
            S_MUL_IA: begin
                mul_a = MA_W'(r_integ);
                mul_b = MB_W'(r_ki);
            end
            S_MUL_FF: begin
                mul_a = MA_W'(r_ff);
                mul_b = MB_W'(FF_SCALE);
            end
            S_DUTY: begin
                mul_a = MA_W'(r_num[33:16]);
                mul_b = MB_W'(DIV1000_RECIP);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_target    <= CFG_W'(768);
            r_kp        <= CFG_W'(1024);
            r_ki        <= CFG_W'(256);
            r_ff        <= CFG_W'(5632);
            r_ilim      <= CFG_W'(12800);
            r_cpr       <= CFG_W'(700);
            r_period    <= CFG_W'(250);
            r_pos       <= '0;
            r_last      <= '0;
            r_ticks     <= '0;
            r_integ     <= '0;
        end else begin
            if (out_acc && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_TARGET_SPEED:   r_target <= i_cfg_data;
                    CFG_PROP_GAIN:      r_kp     <= i_cfg_data;
                    CFG_INTEG_GAIN:     r_ki     <= i_cfg_data;
                    CFG_FRICTION_FF:    r_ff     <= i_cfg_data;
                    CFG_INTEGRAL_LIMIT: r_ilim   <= i_cfg_data;
                    CFG_ENC_CPR:        r_cpr    <= i_cfg_data;
                    CFG_SAMPLE_PERIOD:  r_period <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (!s_axis_tuser) begin
                            if (s_axis_tdata[0]) begin
                                r_pos <= r_pos + COUNT_WIDTH'(1);
                            end else begin
                                r_pos <= r_pos - COUNT_WIDTH'(1);
                            end
                        end else if (ticks_inc < period_eff) begin
                            r_ticks <= ticks_inc;
                        end else begin
                            r_dt    <= ticks_inc;
                            r_mag   <= mag_ext[MAG_W-1:0];
                            r_big   <= (mag_ext > MW'(41'h100_0000_0000));
                            r_last  <= r_pos;
                            r_ticks <= '0;
                            r_state <= S_MUL_LO;
                        end
                    end
                end
                S_MUL_LO: begin
                    r_state <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    r_plo   <= r_prod[37:0];
                    r_state <= S_MUL_DEN;
                end
                S_MUL_DEN: begin
                    r_dvd   <= {spd_prod, {SPD_SHIFT{1'b0}}};
                    r_state <= S_DIV_CHK;
                end
                S_DIV_CHK: begin
                    if (r_big || (r_dvd[DVD_W-1:SPEED_W] >= 40'(r_prod[DEN_W-1:0]))) begin
                        r_speed <= '1;
                        r_state <= S_ERR;
                    end else begin
                        r_rem   <= r_dvd[SPEED_W+DEN_W-1:SPEED_W];
                        r_den   <= r_prod[DEN_W-1:0];
                        r_cnt   <= '0;
                        r_speed <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rem_sh >= {1'b0, r_den}) begin
                        r_rem   <= DEN_W'(rem_sh - {1'b0, r_den});
                        r_speed <= {r_speed[SPEED_W-2:0], 1'b1};
                    end else begin
                        r_rem   <= rem_sh[DEN_W-1:0];
                        r_speed <= {r_speed[SPEED_W-2:0], 1'b0};
                    end
                    r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err   <= $signed(ERR_W'(r_target) - ERR_W'(r_speed));
                    r_state <= S_MUL_EDT;
                end
                S_MUL_EDT: begin
                    r_lim   <= r_prod[LIM_W-1:0];
                    r_state <= S_INTEG;
                end
                S_INTEG: begin
                    if (integ_sum > lim_pos) begin
                        r_integ <= INT_W'(lim_pos);
                    end else if (integ_sum < lim_neg) begin
                        r_integ <= INT_W'(lim_neg);
                    end else begin
                        r_integ <= INT_W'(integ_sum);
                    end
                    r_state <= S_MUL_PE;
                end
                S_MUL_PE: begin
                    r_state <= S_MUL_IA;
                end
                S_MUL_IA: begin
                    r_num   <= r_prod[NUM_W-1:0];
                    r_state <= S_MUL_FF;
                end
                S_MUL_FF: begin
                    r_num   <= r_num + r_prod[NUM_W-1:0];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_num   <= r_num + r_prod[NUM_W-1:0];
                    r_state <= S_DUTY;
                end
                S_DUTY: begin
                    if (r_num[NUM_W-1]) begin
                        r_duty  <= '0;
                        r_state <= S_DONE;
                    end else if (r_num >= NUM_W'(DUTY_FULL)) begin
                        r_duty  <= '1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DUTY2;
                    end
                end
                S_DUTY2: begin
                    r_duty  <= r_prod[DIV1000_SHIFT+DUTY_W-1:DIV1000_SHIFT];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_o_duty    <= r_duty;
                        r_o_speed   <= r_speed;
                        r_o_err     <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- verif/epsc_tb_pkg.sv -----
`timescale 1ns / 1ps
// Testbench-side codes and record types for the encoder PI speed controller.
// No dependencies; imported by the checker and the testbench top.
package epsc_tb_pkg;

    localparam logic KIND_EDGE   = 1'b0;
    localparam logic KIND_TICK   = 1'b1;
    localparam logic CHAN_B_DOWN = 1'b0;
    localparam logic CHAN_B_UP   = 1'b1;

    typedef struct packed {
        logic [15:0] target_speed;
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] ff_duty;
        logic [15:0] integral_limit;
        logic [15:0] enc_cpr;
        logic [15:0] sample_period;
    } t_ctrl_setting;

    typedef struct packed {
        logic [24:0] speed_error;
        logic [23:0] measured_speed;
        logic [7:0]  pwm_duty;
    } t_ctrl_update;

endpackage

// ----- verif/encoder_pi_speed_controller_unit_checker.sv -----
`timescale 1ns / 1ps
// Watches the request, update and register channels of the speed controller,
// computes each expected PI update and compares it with the DUT output.
// Depends on epsc_pkg and epsc_tb_pkg.
module encoder_pi_speed_controller_unit_checker
    import epsc_pkg::*;
    import epsc_tb_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  logic [7:0]           i_req_data,
    input  logic                 i_req_user,
    input  logic                 i_upd_valid,
    input  logic                 i_upd_ready,
    input  logic [63:0]          i_upd_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_pending,
    output int                   o_fail_count,
    output int                   o_update_count
);

    localparam longint unsigned RPM_SCALE  = 64'd15360000;
    localparam longint unsigned SPEED_CEIL = 64'd16777215;
    localparam longint MS_PER_S        = 1000;
    localparam longint FF_WEIGHT       = 256000;
    localparam longint DUTY_UNIT       = 65536000;
    localparam longint DUTY_FULL_SCALE = 256 * DUTY_UNIT;

    logic [15:0] reg_target, reg_kp, reg_ki, reg_ff, reg_limit, reg_cpr, reg_period;
    logic [COUNT_WIDTH-1:0] pos_count, window_start;
    logic [15:0] tick_count;
    longint integ_accum;

    t_ctrl_update expected_updates[$];

    task automatic advance_controller(input logic kind, input logic chan_b);
        logic [COUNT_WIDTH-1:0] delta, mag;
        logic [15:0] period, dt;
        longint unsigned den, rate;
        longint err, lim, acc, num;
        t_ctrl_update upd;
        if (kind == KIND_EDGE) begin
            if (chan_b == CHAN_B_UP) pos_count = pos_count + 1'b1;
            else pos_count = pos_count - 1'b1;
            return;
        end
        tick_count = tick_count + 16'd1;
        period = (reg_period == '0) ? 16'd1 : reg_period;
        if (tick_count < period) return;
        dt = (tick_count == '0) ? 16'd1 : tick_count;

        delta = pos_count - window_start;
        mag = delta[COUNT_WIDTH-1] ? -delta : delta;
        window_start = pos_count;
        tick_count = '0;

        den = (reg_cpr == '0) ? 64'd1 : 64'(reg_cpr);
        den = den * dt;
        if (64'(mag) > (64'd1 << 40)) begin
            rate = SPEED_CEIL;
        end else begin
            rate = (64'(mag) * RPM_SCALE) / den;
            if (rate > SPEED_CEIL) rate = SPEED_CEIL;
        end
        err = longint'(reg_target) - longint'(rate);

        lim = longint'(reg_limit) * MS_PER_S;
        acc = integ_accum + err * longint'(dt);
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        integ_accum = acc;

        num = longint'(reg_ff) * FF_WEIGHT + longint'(reg_kp) * err * MS_PER_S
            + longint'(reg_ki) * acc;
        if (num < 0) upd.pwm_duty = '0;
        else if (num >= DUTY_FULL_SCALE) upd.pwm_duty = 8'hFF;
        else upd.pwm_duty = 8'(num / DUTY_UNIT);
        upd.measured_speed = rate[23:0];
        upd.speed_error = err[24:0];
        expected_updates.push_back(upd);
    endtask

    task automatic check_update(input logic [63:0] data);
        t_ctrl_update want;
        logic [7:0]  duty;
        logic [23:0] speed;
        logic [24:0] serr;
        duty  = data[7:0];
        speed = data[31:8];
        serr  = data[56:32];
        if (expected_updates.size() == 0) begin
            $error("update with none pending: pwm_duty %0d measured_speed %0d", duty, speed);
            o_fail_count++;
            return;
        end
        want = expected_updates.pop_front();
        o_update_count++;
        if (duty !== want.pwm_duty) begin
            $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, duty);
            o_fail_count++;
        end
        if (speed !== want.measured_speed) begin
            $error("measured_speed: expected %0d, got %0d", want.measured_speed, speed);
            o_fail_count++;
        end
        if (serr !== want.speed_error) begin
            $error("speed_error: expected %0d, got %0d",
                   $signed(want.speed_error), $signed(serr));
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_target   = 16'd768;
            reg_kp       = 16'd1024;
            reg_ki       = 16'd256;
            reg_ff       = 16'd5632;
            reg_limit    = 16'd12800;
            reg_cpr      = 16'd700;
            reg_period   = 16'd250;
            pos_count    = '0;
            window_start = '0;
            tick_count   = '0;
            integ_accum  = 0;
            expected_updates.delete();
        end else begin
            if (i_upd_valid && i_upd_ready) check_update(i_upd_data);
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_TARGET_SPEED:   reg_target = i_cfg_data;
                    CFG_PROP_GAIN:      reg_kp     = i_cfg_data;
                    CFG_INTEG_GAIN:     reg_ki     = i_cfg_data;
                    CFG_FRICTION_FF:    reg_ff     = i_cfg_data;
                    CFG_INTEGRAL_LIMIT: reg_limit  = i_cfg_data;
                    CFG_ENC_CPR:        reg_cpr    = i_cfg_data;
                    CFG_SAMPLE_PERIOD:  reg_period = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) advance_controller(i_req_user, i_req_data[0]);
        end
        o_pending <= expected_updates.size();
    end

endmodule

// ----- verif/encoder_pi_speed_controller_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for encoder_pi_speed_controller_unit: clock, reset, encoder and
// tick requests, register settings, pacing, and the verdict.
// Depends on epsc_pkg, epsc_tb_pkg and encoder_pi_speed_controller_unit_checker.
module encoder_pi_speed_controller_unit_tb;
    import epsc_pkg::*;
    import epsc_tb_pkg::*;

    localparam int NUM_PHASES     = 8;
    localparam int PHASE_REQUESTS = 166;
    localparam int SETTLE_CYCLES  = 60;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = 8'd0;
    logic             s_axis_tuser = KIND_EDGE;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [63:0]      m_axis_tdata;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    t_cfg_reg         i_cfg_index = CFG_TARGET_SPEED;
    logic [CFG_W-1:0] i_cfg_data = '0;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int req_total = 0;
    int setting_total = 0;
    int pending;
    int fail_total;
    int update_total;

    encoder_pi_speed_controller_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    encoder_pi_speed_controller_unit_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (s_axis_tvalid),
        .i_req_ready    (s_axis_tready),
        .i_req_data     (s_axis_tdata),
        .i_req_user     (s_axis_tuser),
        .i_upd_valid    (m_axis_tvalid),
        .i_upd_ready    (m_axis_tready),
        .i_upd_data     (m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending),
        .o_fail_count   (fail_total),
        .o_update_count (update_total)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_request(input logic kind, input logic chan_b);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, chan_b};
        do @(posedge i_clk); while (!s_axis_tready);
        req_total++;
    endtask

    task automatic wait_for_updates();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_setting(input t_ctrl_setting s);
        wait_for_updates();
        write_reg(CFG_TARGET_SPEED,   s.target_speed);
        write_reg(CFG_PROP_GAIN,      s.prop_gain);
        write_reg(CFG_INTEG_GAIN,     s.integ_gain);
        write_reg(CFG_FRICTION_FF,    s.ff_duty);
        write_reg(CFG_INTEGRAL_LIMIT, s.integral_limit);
        write_reg(CFG_ENC_CPR,        s.enc_cpr);
        write_reg(CFG_SAMPLE_PERIOD,  s.sample_period);
        i_cfg_valid <= 1'b0;
        setting_total++;
    endtask

    function automatic logic [15:0] pick_value(input int lo, input int hi);
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(hi, lo));
        endcase
    endfunction

    initial begin
        t_ctrl_setting s;
        int tick_pct;
        int up_pct;
        logic kind;
        logic chan_b;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero period, zero counts per rev, zero integral limit, maximum gains
        s = '{target_speed: 16'hFFFF, prop_gain: 16'hFFFF, integ_gain: 16'hFFFF,
              ff_duty: 16'hFFFF, integral_limit: 16'h0000,
              enc_cpr: 16'h0000, sample_period: 16'h0000};
        apply_setting(s);
        send_request(KIND_EDGE, CHAN_B_DOWN);
        send_request(KIND_EDGE, CHAN_B_DOWN);
        send_request(KIND_EDGE, CHAN_B_UP);
        send_request(KIND_TICK, CHAN_B_UP);
        send_request(KIND_TICK, CHAN_B_DOWN);
        send_request(KIND_EDGE, CHAN_B_UP);
        send_request(KIND_EDGE, CHAN_B_UP);
        send_request(KIND_EDGE, CHAN_B_UP);
        send_request(KIND_TICK, CHAN_B_DOWN);

        // longest window, then shorten it while ticks are already counted
        s = '{target_speed: 16'h0000, prop_gain: 16'h0000, integ_gain: 16'h0000,
              ff_duty: 16'h0000, integral_limit: 16'hFFFF,
              enc_cpr: 16'hFFFF, sample_period: 16'hFFFF};
        apply_setting(s);
        send_request(KIND_EDGE, CHAN_B_UP);
        send_request(KIND_EDGE, CHAN_B_DOWN);
        send_request(KIND_TICK, CHAN_B_UP);
        send_request(KIND_TICK, CHAN_B_DOWN);
        send_request(KIND_EDGE, CHAN_B_UP);
        send_request(KIND_TICK, CHAN_B_UP);
        send_request(KIND_TICK, CHAN_B_DOWN);
        s = '{target_speed: 16'd1000, prop_gain: 16'd256, integ_gain: 16'd512,
              ff_duty: 16'd2560, integral_limit: 16'd100,
              enc_cpr: 16'hFFFF, sample_period: 16'd2};
        apply_setting(s);
        send_request(KIND_TICK, CHAN_B_UP);
        send_request(KIND_EDGE, CHAN_B_UP);
        send_request(KIND_TICK, CHAN_B_DOWN);
        send_request(KIND_TICK, CHAN_B_UP);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            s.target_speed   = pick_value(0, 40000);
            s.prop_gain      = pick_value(0, 2048);
            s.integ_gain     = pick_value(0, 2048);
            s.ff_duty        = pick_value(0, 20000);
            s.integral_limit = pick_value(0, 65535);
            s.enc_cpr        = pick_value(1, 2000);
            s.sample_period  = ($urandom_range(7) == 0) ? 16'($urandom_range(40, 9))
                                                        : 16'($urandom_range(6, 0));
            apply_setting(s);
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 68; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 68; end
                default: begin src_idle_pct = 18; sink_stall_pct = 18; end
            endcase
            tick_pct = $urandom_range(60, 15);
            up_pct   = $urandom_range(100, 0);
            for (int i = 0; i < PHASE_REQUESTS; i++) begin
                if (phase % 2 == 1 && i == PHASE_REQUESTS / 2) wait_for_updates();
                kind   = ($urandom_range(99) < tick_pct) ? KIND_TICK : KIND_EDGE;
                chan_b = ($urandom_range(99) < up_pct) ? CHAN_B_UP : CHAN_B_DOWN;
                send_request(kind, chan_b);
            end
        end

        wait_for_updates();
        $display("Sent %0d encoder edges and ticks under %0d register settings,",
                 req_total, setting_total);
        $display("%0d PI updates compared over all pacing modes.", update_total);
        if (fail_total == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/epsc_pkg.sv
sv/encoder_pi_speed_controller_unit.sv
verif/epsc_tb_pkg.sv
verif/encoder_pi_speed_controller_unit_checker.sv
verif/encoder_pi_speed_controller_unit_tb.sv
